>>> design/nbcc_pkg.sv
// Shared constants and class codes for the narrow-band cell classifier.
package nbcc_pkg;

    localparam int LEVEL_BITS_DEF  = 24;
    localparam int OBJECT_BITS_DEF = 8;

    localparam int CUTOFF_BITS = 23;
    localparam logic [CUTOFF_BITS-1:0] INNER_CUTOFF_RST = CUTOFF_BITS'(1024);
    localparam logic [CUTOFF_BITS-1:0] OUTER_CUTOFF_RST = CUTOFF_BITS'(1536);

    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_INNER = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_OUTER = CFG_IDX_BITS'(1);

    localparam int NUM_NEIGHBOURS = 4;

    typedef enum logic [2:0] {
        CLASS_OUTSIDE   = 3'd0,
        CLASS_EDGE      = 3'd1,
        CLASS_INSIDE    = 3'd2,
        CLASS_INNER     = 3'd3,
        CLASS_INTERFACE = 3'd4
    } t_cell_class;

endpackage

>>> design/narrow_band_cell_classifier.sv
// Top level: narrow-band level set cell classifier, one 2D cell per word.
//
// Usage
//   Slave stream (s_axis_*) carries one cell per word: the centre level and
//   its west, east, south and north neighbour levels (signed Q15.8, the
//   caller repeats the centre value at a domain edge), then the five object
//   ids. s_axis_tlast marks the last cell of a tile.
//   Master stream (m_axis_*) returns one result word per cell, in order:
//   class, band mask, interface object id and the tile band flag. The tile
//   flag is the OR of band masks over the tile and is non-zero only on the
//   word of a cell that came in with tlast set.
//   Config channel (i_cfg_*) writes the inner cutoff (index 0) and the outer
//   cutoff (index 1); it is always ready and should only be used when idle.
// Timing
//   Two register stages: input register, then result register. A word
//   accepted into the input register moves on to the result register
//   once that register is free. One word per clock is sustained while
//   m_axis_tready stays high; compare/abs logic lies between the stages.
// Reset and stall
//   Synchronous active-low reset empties both stages, clears the tile
//   accumulator and loads the cutoffs with 4.0 and 6.0 cell widths.
//   If m_axis_tready is held low the result register holds its word, the
//   input register takes one more word if empty, then s_axis_tready drops.
module narrow_band_cell_classifier
    import nbcc_pkg::*;
#(
    parameter int LEVEL_BITS  = LEVEL_BITS_DEF,
    parameter int OBJECT_BITS = OBJECT_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    // cfg write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CUTOFF_BITS-1:0]  i_cfg_data,

    // input cells
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // tdata, lowest bit up: center_level, west_level, east_level,
    // south_level, north_level, center_object, west_object, east_object,
    // south_object, north_object, zero fill
    input  logic [((5*LEVEL_BITS+5*OBJECT_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                    s_axis_tlast,   // last_in_tile

    // results
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // tdata, lowest bit up: cell_class[2:0], band_mask, interface_object,
    // tile_has_band, zero fill
    output logic [((5+OBJECT_BITS+7)/8)*8-1:0] m_axis_tdata
);

    localparam int IN_W    = ((5*LEVEL_BITS+5*OBJECT_BITS+7)/8)*8;
    localparam int OUT_W   = ((5+OBJECT_BITS+7)/8)*8;
    localparam int OBJ_LSB = 5*LEVEL_BITS;
    localparam int CMP_W   = (LEVEL_BITS > CUTOFF_BITS) ? LEVEL_BITS : CUTOFF_BITS;

    // config registers
    logic [CUTOFF_BITS-1:0] r_inner_cutoff;
    logic [CUTOFF_BITS-1:0] r_outer_cutoff;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_cutoff <= INNER_CUTOFF_RST;
            r_outer_cutoff <= OUTER_CUTOFF_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDX_INNER: r_inner_cutoff <= i_cfg_data;
                CFG_IDX_OUTER: r_outer_cutoff <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic             r_in_valid;
    logic [IN_W-1:0]  r_in_data;
    logic             r_in_last;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic             r_tile_seen;
    logic             out_free;
    logic             advance;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // unpack the held word
    logic [LEVEL_BITS-1:0]  c_level;
    logic [LEVEL_BITS-1:0]  nb_level [NUM_NEIGHBOURS];
    logic [OBJECT_BITS-1:0] c_obj;
    logic [OBJECT_BITS-1:0] nb_obj   [NUM_NEIGHBOURS];

    always_comb begin
        c_level = r_in_data[0 +: LEVEL_BITS];
        c_obj   = r_in_data[OBJ_LSB +: OBJECT_BITS];
        for (int k = 0; k < NUM_NEIGHBOURS; k++) begin
            nb_level[k] = r_in_data[(k+1)*LEVEL_BITS +: LEVEL_BITS];
            nb_obj[k]   = r_in_data[OBJ_LSB + (k+1)*OBJECT_BITS +: OBJECT_BITS];
        end
    end

    // magnitudes; most negative value maps to 2^(LEVEL_BITS-1), still unsigned-correct
    function automatic logic [CMP_W-1:0] mag_of(input logic [LEVEL_BITS-1:0] v);
        logic [LEVEL_BITS-1:0] m;
        begin
            m = v[LEVEL_BITS-1] ? (~v + LEVEL_BITS'(1)) : v;
            return CMP_W'(m);
        end
    endfunction

    logic [CMP_W-1:0] inner_ext, outer_ext;
    logic             is_inside, is_inner, is_edge;
    logic             c_pos, c_zero;
    logic [OBJECT_BITS-1:0] iface;
    logic             iface_hit;
    t_cell_class      cls;
    logic             band;
    logic             tile_has_band;

    assign inner_ext = CMP_W'(r_inner_cutoff);
    assign outer_ext = CMP_W'(r_outer_cutoff);

    always_comb begin
        logic [OBJECT_BITS-1:0] cand;
        logic                   nb_pos;
        is_inside = mag_of(c_level) < outer_ext;
        is_inner  = mag_of(c_level) < inner_ext;
        c_pos     = !c_level[LEVEL_BITS-1] && (|c_level);
        c_zero    = !(|c_level);

        // edge: outside the tube but a neighbour is in it
        is_edge = 1'b0;
        for (int k = 0; k < NUM_NEIGHBOURS; k++) begin
            if (mag_of(nb_level[k]) < outer_ext) is_edge = 1'b1;
        end
        is_edge = is_edge && !is_inside;

        // first crossing in W, E, S, N order with a non-zero larger id
        iface = '0;
        for (int k = 0; k < NUM_NEIGHBOURS; k++) begin
            nb_pos = !nb_level[k][LEVEL_BITS-1] && (|nb_level[k]);
            cand   = (c_obj > nb_obj[k]) ? c_obj : nb_obj[k];
            if (is_inner && (iface == '0) && (c_zero || (nb_pos != c_pos)))
                iface = cand;
        end
        iface_hit = |iface;

        if (iface_hit)      cls = CLASS_INTERFACE;
        else if (is_inner)  cls = CLASS_INNER;
        else if (is_inside) cls = CLASS_INSIDE;
        else if (is_edge)   cls = CLASS_EDGE;
        else                cls = CLASS_OUTSIDE;

        band          = (cls != CLASS_OUTSIDE);
        tile_has_band = r_in_last && (r_tile_seen || band);
    end

    // tile accumulator, updated as each word moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_seen <= 1'b0;
        end else if (advance) begin
            r_tile_seen <= r_in_last ? 1'b0 : (r_tile_seen || band);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= OUT_W'({tile_has_band, iface, band, cls});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // checks
    a_iface_needs_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_data[2:0] == CLASS_INTERFACE) |-> (|r_out_data[4 +: OBJECT_BITS]))
        else $error("interface class without object id");

    a_id_only_on_iface: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_data[2:0] != CLASS_INTERFACE) |-> !(|r_out_data[4 +: OBJECT_BITS]))
        else $error("object id on non-interface class");

    a_tile_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(advance) && $past(r_in_last) |-> !r_tile_seen)
        else $error("tile accumulator not cleared after tile end");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_out_valid && !m_axis_tready)
        else $error("input stalled with a free stage");

    a_band_matches_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_data[3] == (r_out_data[2:0] != CLASS_OUTSIDE))
        else $error("band mask disagrees with class");

endmodule

>>> test/tb_narrow_band_cell_classifier.sv
// Self-checking testbench for the narrow-band cell classifier stream block.
`timescale 1ns / 100ps

module tb_narrow_band_cell_classifier;
    import nbcc_pkg::*;

    localparam int LEVEL_W = LEVEL_BITS_DEF;
    localparam int OBJ_W   = OBJECT_BITS_DEF;
    localparam int IN_W    = ((5 * LEVEL_W + 5 * OBJ_W + 7) / 8) * 8;
    localparam int OUT_W   = ((5 + OBJ_W + 7) / 8) * 8;

    localparam int LVL_MIN = -(1 << (LEVEL_W - 1));
    localparam int LVL_MAX = (1 << (LEVEL_W - 1)) - 1;
    localparam int CUT_MAX = (1 << CUTOFF_BITS) - 1;

    // stencil positions inside a cell word
    localparam int CENTRE = 0;
    localparam int WEST   = 1;
    localparam int EAST   = 2;
    localparam int SOUTH  = 3;
    localparam int NORTH  = 4;

    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 120;
    // two register stages, plus margin
    localparam int DRAIN_CYCLES    = 8;

    // one input word: lvl[0] / obj[0] is the centre, then W, E, S, N
    typedef struct packed {
        logic                       last;
        logic [4:0][OBJ_W-1:0]      obj;
        logic [4:0][LEVEL_W-1:0]    lvl;
    } t_cell_word;

    typedef struct packed {
        t_cell_class                cls;
        logic                       mask;
        logic [OBJ_W-1:0]           iface;
        logic                       tile;
    } t_cell_result;

    // directed table row; known rows carry a hand-worked result
    typedef struct packed {
        t_cell_word                 stim;
        logic                       known;
        t_cell_result               want;
    } t_directed_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]    i_cfg_index;
    logic [CUTOFF_BITS-1:0]     i_cfg_data;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    // tdata, lowest bit up: centre/west/east/south/north levels, then the
    // five object ids in the same order
    logic [IN_W-1:0]            s_axis_tdata;
    logic                       s_axis_tlast;       // last_in_tile
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    // tdata, lowest bit up: cell_class, band_mask, interface_object,
    // tile_has_band, zero fill
    logic [OUT_W-1:0]           m_axis_tdata;

    // predictor state: its own copy of the cutoffs and tile accumulator
    logic [CUTOFF_BITS-1:0]     inner_cut;
    logic [CUTOFF_BITS-1:0]     outer_cut;
    logic                       tile_band_acc;

    t_cell_result               expected_results[$];
    t_cell_result               head_result;
    t_directed_row              dir_rows[$];
    int unsigned                failures;
    logic                       idling;

    narrow_band_cell_classifier dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest legal run (~1k words, idle gaps
    // on both sides).
    initial begin
        #5_000_000;
        $display("narrow_band_cell_classifier: mismatch");
        $finish;
    end

    // |v| as an unsigned LEVEL_W-bit value; the most negative level maps to
    // 2^(LEVEL_W-1), which no 23-bit cutoff can exceed
    function automatic logic [LEVEL_W-1:0] level_mag(input logic [LEVEL_W-1:0] v);
        return v[LEVEL_W-1] ? -v : v;
    endfunction

    // Predictor: class, mask and interface id for one cell, and the tile
    // flag; advances the tile accumulator as the block does.
    function automatic t_cell_result classify_cell(input t_cell_word c);
        t_cell_result               r;
        logic signed [LEVEL_W-1:0]  centre;
        logic [LEVEL_W-1:0]         mag;
        logic                       in_tube;
        logic                       in_inner;
        logic                       near_tube;
        logic                       centre_pos;
        logic                       centre_zero;
        logic [OBJ_W-1:0]           larger;
        centre      = c.lvl[CENTRE];
        mag         = level_mag(c.lvl[CENTRE]);
        in_tube     = mag < LEVEL_W'(outer_cut);
        in_inner    = mag < LEVEL_W'(inner_cut);
        centre_pos  = centre > 0;
        centre_zero = centre == 0;
        near_tube   = 1'b0;
        r           = '0;

        // edge: outside the tube but next to a neighbour inside it
        if (!in_tube) begin
            for (int k = WEST; k <= NORTH; k++) begin
                if (level_mag(c.lvl[k]) < LEVEL_W'(outer_cut))
                    near_tube = 1'b1;
            end
        end

        // first sign change W, E, S, N; a zero centre crosses everything,
        // and a crossing whose larger id is zero lets the search go on
        if (in_inner) begin
            for (int k = WEST; k <= NORTH; k++) begin
                if (r.iface == '0 &&
                    (centre_zero || (($signed(c.lvl[k]) > 0) != centre_pos))) begin
                    larger  = (c.obj[CENTRE] > c.obj[k]) ? c.obj[CENTRE] : c.obj[k];
                    r.iface = larger;
                end
            end
        end

        if (r.iface != '0)
            r.cls = CLASS_INTERFACE;
        else if (in_inner)
            r.cls = CLASS_INNER;
        else if (in_tube)
            r.cls = CLASS_INSIDE;
        else if (near_tube)
            r.cls = CLASS_EDGE;
        else
            r.cls = CLASS_OUTSIDE;
        r.mask = (r.cls != CLASS_OUTSIDE);

        if (c.last) begin
            r.tile        = tile_band_acc | r.mask;
            tile_band_acc = 1'b0;
        end else begin
            r.tile        = 1'b0;
            tile_band_acc = tile_band_acc | r.mask;
        end
        return r;
    endfunction

    function automatic t_cell_word make_cell(input int cl, wl, el, sl, nl,
                                             input int co, wo, eo, so, nbo,
                                             input bit last);
        t_cell_word c;
        c.lvl[CENTRE] = LEVEL_W'(cl);
        c.lvl[WEST]   = LEVEL_W'(wl);
        c.lvl[EAST]   = LEVEL_W'(el);
        c.lvl[SOUTH]  = LEVEL_W'(sl);
        c.lvl[NORTH]  = LEVEL_W'(nl);
        c.obj[CENTRE] = OBJ_W'(co);
        c.obj[WEST]   = OBJ_W'(wo);
        c.obj[EAST]   = OBJ_W'(eo);
        c.obj[SOUTH]  = OBJ_W'(so);
        c.obj[NORTH]  = OBJ_W'(nbo);
        c.last        = last;
        return c;
    endfunction

    task automatic cell_row(input int cl, wl, el, sl, nl,
                            input int co, wo, eo, so, nbo, input bit last);
        dir_rows.push_back('{make_cell(cl, wl, el, sl, nl, co, wo, eo, so, nbo, last),
                             1'b0, '0});
    endtask

    task automatic known_row(input int cl, wl, el, sl, nl,
                             input int co, wo, eo, so, nbo, input bit last,
                             input t_cell_class cls, input bit mask,
                             input int iface, input bit tile);
        t_cell_result w;
        w.cls   = cls;
        w.mask  = mask;
        w.iface = OBJ_W'(iface);
        w.tile  = tile;
        dir_rows.push_back('{make_cell(cl, wl, el, sl, nl, co, wo, eo, so, nbo, last),
                             1'b1, w});
    endtask

    // Levels clustered round zero and both cutoffs, with a share of
    // full-range and extreme values.
    function automatic logic [LEVEL_W-1:0] pick_level();
        logic [LEVEL_W-1:0] v;
        case ($urandom_range(0, 9))
            0:          v = LEVEL_W'($urandom);
            1:          v = $urandom_range(0, 1) ? LEVEL_W'(LVL_MIN) : LEVEL_W'(LVL_MAX);
            2, 3, 4:    v = LEVEL_W'(inner_cut + $urandom_range(0, 6) - 3);
            5, 6:       v = LEVEL_W'(outer_cut + $urandom_range(0, 6) - 3);
            default:    v = LEVEL_W'($urandom_range(0, 2 * outer_cut + 64));
        endcase
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    function automatic logic [OBJ_W-1:0] pick_object();
        return ($urandom_range(0, 3) == 0) ? '0 : OBJ_W'($urandom_range(0, 255));
    endfunction

    function automatic t_cell_word random_cell();
        t_cell_word c;
        c.lvl[CENTRE] = pick_level();
        c.obj[CENTRE] = pick_object();
        for (int k = WEST; k <= NORTH; k++) begin
            case ($urandom_range(0, 9))
                // domain edge: caller repeats the centre
                0:          c.lvl[k] = c.lvl[CENTRE];
                // close neighbour, often across zero near the interface
                1, 2, 3, 4: c.lvl[k] = c.lvl[CENTRE] + LEVEL_W'($urandom_range(0, 16) - 8);
                default:    c.lvl[k] = pick_level();
            endcase
            c.obj[k] = pick_object();
        end
        c.last = ($urandom_range(0, 7) == 0);
        return c;
    endfunction

    // Offers one word (after an optional idle burst) and logs its
    // expectation at the accepting edge. Entered and left at a falling edge.
    task automatic send_cell(input t_cell_word c, input logic known,
                             input t_cell_result want);
        t_cell_result predicted;
        if (idling && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = IN_W'({c.obj, c.lvl});
        s_axis_tlast  = c.last;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = classify_cell(c);
        expected_results.push_back(known ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic write_cutoff(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [CUTOFF_BITS-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_IDX_INNER)
            inner_cut = val;
        else if (idx == CFG_IDX_OUTER)
            outer_cut = val;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Every result has arrived and both stages are empty.
    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic check_field(input string what, input int unsigned want, got);
        if (want != got) begin
            failures++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // Result side: random stall bursts while idling is on.
    initial begin
        m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (idling && $urandom_range(0, 5) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Result checker: each accepted word against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                failures++;
                $display("%0t: result word expected none, got %h", $time, m_axis_tdata);
            end else begin
                head_result = expected_results.pop_front();
                check_field("cell_class", head_result.cls, m_axis_tdata[2:0]);
                check_field("band_mask", head_result.mask, m_axis_tdata[3]);
                check_field("interface_object", head_result.iface,
                            m_axis_tdata[4 +: OBJ_W]);
                check_field("tile_has_band", head_result.tile, m_axis_tdata[4 + OBJ_W]);
            end
        end
    end

    initial begin
        t_cell_word stim_word;
        logic [CUTOFF_BITS-1:0] new_inner;
        logic [CUTOFF_BITS-1:0] new_outer;

        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_IDX_INNER;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        idling        = 1'b1;
        failures      = 0;
        inner_cut     = INNER_CUTOFF_RST;
        outer_cut     = OUTER_CUTOFF_RST;
        tile_band_acc = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, reset cutoffs (inner 1024, outer 1536).
        // Hand-worked rows first; the tile flag column follows the row order.
        // all zero: zero centre crosses everywhere but every id is 0
        known_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, CLASS_INNER, 1, 0, 0);
        // zero-id crossing on the west is skipped, east gives id 5; tile end
        known_row(0, 0, 0, 0, 0, 0, 0, 5, 9, 7, 1, CLASS_INTERFACE, 1, 5, 1);
        // most negative level everywhere: never in the band
        known_row(LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN, 255, 255, 255, 255, 255, 1,
                  CLASS_OUTSIDE, 0, 0, 0);
        known_row(LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX, 255, 255, 255, 255, 255, 0,
                  CLASS_OUTSIDE, 0, 0, 0);
        // edge through the west neighbour, closing a tile
        known_row(2000, 100, 2000, 2000, 2000, 0, 0, 0, 0, 0, 1, CLASS_EDGE, 1, 0, 1);
        // inside the tube: sign change ignored outside the inner band
        known_row(1200, -500, -500, -500, -500, 3, 4, 4, 4, 4, 0, CLASS_INSIDE, 1, 0, 0);

        // cutoff boundaries (strict compare)
        cell_row(1024, 1024, 1024, 1024, 1024, 1, 2, 3, 4, 5, 0);
        cell_row(-1024, 1, 1, 1, 1, 9, 9, 9, 9, 9, 0);
        cell_row(1023, 1023, 1023, 1023, 1023, 0, 0, 0, 0, 0, 0);
        cell_row(1535, LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX, 8, 0, 0, 0, 0, 1);
        cell_row(1536, 1600, -1535, 1600, 1600, 0, 0, 0, 0, 0, 0);
        cell_row(-1536, -1536, -1536, -1536, -1536, 0, 0, 0, 0, 0, 1);
        // zero neighbour is not positive, so no crossing there; south crosses
        cell_row(-1023, -5, 0, 3, -2, 3, 100, 150, 200, 250, 0);
        // zero-id crossings skipped until south
        cell_row(10, -10, -10, -10, -10, 0, 0, 0, 77, 99, 0);
        cell_row(1, 1, 1, 1, LVL_MIN, 254, 0, 0, 0, 255, 0);
        cell_row(-1, -1, 1, 0, 0, 170, 85, 0, 0, 0, 1);
        cell_row(0, LVL_MAX, LVL_MIN, -1, 1, 85, 170, 0, 0, 0, 0);
        cell_row(LVL_MIN, 0, LVL_MIN, LVL_MIN, LVL_MIN, 1, 1, 1, 1, 1, 0);
        cell_row(LVL_MAX, -1, -1, -1, -1, 0, 0, 0, 0, 0, 1);
        cell_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);

        foreach (dir_rows[i])
            send_cell(dir_rows[i].stim, dir_rows[i].known, dir_rows[i].want);

        // Random part: one cutoff setting per phase, written while idle.
        // Phase 0 keeps the reset values; the last phase runs without idling.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            s_axis_tvalid = 1'b0;
            wait_drained();
            case (ph)
                1:          begin new_inner = '0;                   new_outer = '0;      end
                2:          begin new_inner = CUT_MAX;              new_outer = CUT_MAX; end
                3:          begin new_inner = 3000;                 new_outer = 500;     end
                4:          begin new_inner = 256;                  new_outer = 768;     end
                5:          begin
                    new_inner = CUTOFF_BITS'($urandom_range(0, 4095));
                    new_outer = CUTOFF_BITS'($urandom_range(0, 4095));
                end
                default:    begin new_inner = INNER_CUTOFF_RST;     new_outer = OUTER_CUTOFF_RST; end
            endcase
            if (ph != 0) begin
                write_cutoff(CFG_IDX_INNER, new_inner);
                write_cutoff(CFG_IDX_OUTER, new_outer);
            end
            idling = (ph != NUM_PHASES - 1);
            repeat (ITEMS_PER_PHASE) begin
                stim_word = random_cell();
                send_cell(stim_word, 1'b0, '0);
            end
        end

        s_axis_tvalid = 1'b0;
        wait_drained();

        if (failures == 0 && expected_results.size() == 0)
            $display("narrow_band_cell_classifier: match");
        else
            $display("narrow_band_cell_classifier: mismatch");
        $finish;
    end

endmodule
